[src/itw_pkg.sv]
// Shared types, constants and word codes for the integer-to-word-tokens block.
// Used by every module under src; depends on nothing.
package itw_pkg;

    localparam int VALUE_W = 31;              // input value width
    localparam int CODE_W  = 5;               // word code width
    localparam int DIGITS  = 10;              // decimal digits of a 31-bit value
    localparam int BCD_W   = 4 * DIGITS;      // packed BCD width
    localparam int GROUPS  = 4;               // base-1000 groups
    localparam int GRP_W   = 12;              // three BCD digits per group
    localparam int CNT_W   = $clog2(VALUE_W + 1);
    localparam int PC_W    = 5;

    // Word codes
    localparam logic [CODE_W-1:0] W_ZERO       = 5'd0;
    localparam logic [CODE_W-1:0] W_TEN        = 5'd10;
    localparam logic [CODE_W-1:0] W_TENS_BASE  = 5'd18;  // plus tens digit 2..9
    localparam logic [CODE_W-1:0] W_HUNDRED    = 5'd28;
    localparam logic [CODE_W-1:0] W_SCALE_BASE = 5'd28;  // plus group 1..3

    // Program layout
    localparam logic [PC_W-1:0] PC_SHIFT = 5'd0;
    localparam logic [PC_W-1:0] PC_G3    = 5'd1;
    localparam logic [PC_W-1:0] PC_G2    = 5'd6;
    localparam logic [PC_W-1:0] PC_G1    = 5'd11;
    localparam logic [PC_W-1:0] PC_G0    = 5'd16;
    localparam logic [PC_W-1:0] PC_END   = 5'd20;

    typedef enum logic [2:0] {
        OP_SHIFT   = 3'd0,
        OP_HDIGIT  = 3'd1,
        OP_HUNDRED = 3'd2,
        OP_TENS    = 3'd3,
        OP_UNITS   = 3'd4,
        OP_SCALE   = 3'd5,
        OP_END     = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        C_NEVER      = 2'd0,
        C_MORE_BITS  = 2'd1,
        C_GROUP_ZERO = 2'd2
    } cond_t;

    // One control word of the program
    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [1:0]      grp;
        logic [PC_W-1:0] target;
    } ctl_t;

    // Word decode result for the current step
    typedef struct packed {
        logic              emit;
        logic [CODE_W-1:0] code;
        logic              group_zero;
    } word_t;

endpackage

[src/itw_bcd.sv]
// Binary to BCD converter, one input bit per shift (shift-and-add-3).
// Depends on itw_pkg.
module itw_bcd
    import itw_pkg::*;
(
    input  logic               aclk,
    input  logic               load,
    input  logic               shift,
    input  logic [VALUE_W-1:0] value,
    output logic [BCD_W-1:0]   bcd
);

    logic [VALUE_W-1:0] bin_reg;
    logic [VALUE_W-1:0] bin_next;
    logic [BCD_W-1:0]   bcd_reg;
    logic [BCD_W-1:0]   bcd_next;
    logic [BCD_W-1:0]   adj;

    // Correct every digit of five or more, then shift in the next bit
    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            if (bcd_reg[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            end else begin
                adj[4*d +: 4] = bcd_reg[4*d +: 4];
            end
        end
        bcd_next = bcd_reg;
        bin_next = bin_reg;
        if (load) begin
            bcd_next = '0;
            bin_next = value;
        end else if (shift) begin
            bcd_next = {adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        bcd_reg <= bcd_next;
        bin_reg <= bin_next;
    end

    assign bcd = bcd_reg;

endmodule

[src/itw_rom.sv]
// Microcode store: one control word per program step.
// Depends on itw_pkg.
module itw_rom
    import itw_pkg::*;
(
    input  logic [PC_W-1:0] pc,
    output ctl_t            ctl
);

    function automatic ctl_t mk(op_t op, cond_t cond, logic [1:0] grp,
                                logic [PC_W-1:0] target);
        ctl_t c;
        c.op     = op;
        c.cond   = cond;
        c.grp    = grp;
        c.target = target;
        return c;
    endfunction

    // Convert, then walk the groups from billions down; a zero group jumps ahead
    always_comb begin
        unique case (pc)
            PC_SHIFT:     ctl = mk(OP_SHIFT,   C_MORE_BITS,  2'd0, PC_SHIFT);
            PC_G3:        ctl = mk(OP_HDIGIT,  C_GROUP_ZERO, 2'd3, PC_G2);
            PC_G3 + 5'd1: ctl = mk(OP_HUNDRED, C_NEVER,      2'd3, PC_END);
            PC_G3 + 5'd2: ctl = mk(OP_TENS,    C_NEVER,      2'd3, PC_END);
            PC_G3 + 5'd3: ctl = mk(OP_UNITS,   C_NEVER,      2'd3, PC_END);
            PC_G3 + 5'd4: ctl = mk(OP_SCALE,   C_NEVER,      2'd3, PC_END);
            PC_G2:        ctl = mk(OP_HDIGIT,  C_GROUP_ZERO, 2'd2, PC_G1);
            PC_G2 + 5'd1: ctl = mk(OP_HUNDRED, C_NEVER,      2'd2, PC_END);
            PC_G2 + 5'd2: ctl = mk(OP_TENS,    C_NEVER,      2'd2, PC_END);
            PC_G2 + 5'd3: ctl = mk(OP_UNITS,   C_NEVER,      2'd2, PC_END);
            PC_G2 + 5'd4: ctl = mk(OP_SCALE,   C_NEVER,      2'd2, PC_END);
            PC_G1:        ctl = mk(OP_HDIGIT,  C_GROUP_ZERO, 2'd1, PC_G0);
            PC_G1 + 5'd1: ctl = mk(OP_HUNDRED, C_NEVER,      2'd1, PC_END);
            PC_G1 + 5'd2: ctl = mk(OP_TENS,    C_NEVER,      2'd1, PC_END);
            PC_G1 + 5'd3: ctl = mk(OP_UNITS,   C_NEVER,      2'd1, PC_END);
            PC_G1 + 5'd4: ctl = mk(OP_SCALE,   C_NEVER,      2'd1, PC_END);
            PC_G0:        ctl = mk(OP_HDIGIT,  C_GROUP_ZERO, 2'd0, PC_END);
            PC_G0 + 5'd1: ctl = mk(OP_HUNDRED, C_NEVER,      2'd0, PC_END);
            PC_G0 + 5'd2: ctl = mk(OP_TENS,    C_NEVER,      2'd0, PC_END);
            PC_G0 + 5'd3: ctl = mk(OP_UNITS,   C_NEVER,      2'd0, PC_END);
            default:      ctl = mk(OP_END,     C_NEVER,      2'd0, PC_END);
        endcase
    end

endmodule

[src/itw_word.sv]
// Word datapath: picks a group's digits and forms the word for one step.
// Depends on itw_pkg.
module itw_word
    import itw_pkg::*;
(
    input  ctl_t             ctl,
    input  logic [BCD_W-1:0] bcd,
    output word_t            word
);

    logic [GROUPS*GRP_W-1:0] bcd_ext;
    logic [GRP_W-1:0]        grp_bits;
    logic [3:0]              h;
    logic [3:0]              t;
    logic [3:0]              u;

    assign bcd_ext  = {{(GROUPS*GRP_W-BCD_W){1'b0}}, bcd};
    assign grp_bits = bcd_ext[ctl.grp*GRP_W +: GRP_W];
    assign h        = grp_bits[11:8];
    assign t        = grp_bits[7:4];
    assign u        = grp_bits[3:0];

    // Decide whether this step produces a word, and which
    always_comb begin
        word.group_zero = (grp_bits == '0);
        word.emit       = 1'b0;
        word.code       = W_ZERO;
        unique case (ctl.op)
            OP_HDIGIT: begin
                word.emit = (h != 4'd0);
                word.code = {1'b0, h};
            end
            OP_HUNDRED: begin
                word.emit = (h != 4'd0);
                word.code = W_HUNDRED;
            end
            OP_TENS: begin
                word.emit = (t != 4'd0);
                if (t == 4'd1) begin
                    word.code = W_TEN + {1'b0, u};
                end else begin
                    word.code = W_TENS_BASE + {1'b0, t};
                end
            end
            OP_UNITS: begin
                word.emit = (t != 4'd1) && (u != 4'd0);
                word.code = {1'b0, u};
            end
            OP_SCALE: begin
                word.emit = 1'b1;
                word.code = W_SCALE_BASE + {3'b0, ctl.grp};
            end
            OP_SHIFT, OP_END: begin
                word.emit = 1'b0;
            end
            default: begin
                word.emit = 1'b0;
            end
        endcase
    end

endmodule

[src/integer_to_word_tokens_top.sv]
// Integer to English word codes, microcoded sequencer over a BCD datapath.
// Sequence: one conversion step per input bit, then one step per program word; output stalls
// hold the sequencer, and a new value is accepted only once the end step has run.
// Throughput: one value at a time; words leave one per cycle at most, last flagged.
// Reset: aresetn synchronous, active low; clears the sequencer and output valid.
// Depends on itw_pkg, itw_bcd, itw_rom, itw_word.
module integer_to_word_tokens_top
    import itw_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [VALUE_W-1:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CODE_W-1:0]  m_word_code,
    output logic               m_last_word
);

    logic              busy_reg, busy_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [CODE_W-1:0] pend_code_reg, pend_code_next;
    logic              m_valid_reg, m_valid_next;
    logic [CODE_W-1:0] m_code_reg, m_code_next;
    logic              m_last_reg, m_last_next;

    ctl_t              ctl;
    word_t             word;
    logic [BCD_W-1:0]  bcd;
    logic              accept;
    logic              out_free;
    logic              is_end;
    logic              do_emit;
    logic              push_out;
    logic              step_go;
    logic              jump;

    itw_rom u_rom (
        .pc  (pc_reg),
        .ctl (ctl)
    );

    itw_bcd u_bcd (
        .aclk  (aclk),
        .load  (accept),
        .shift (step_go && (ctl.op == OP_SHIFT)),
        .value (s_value),
        .bcd   (bcd)
    );

    itw_word u_word (
        .ctl  (ctl),
        .bcd  (bcd),
        .word (word)
    );

    assign s_ready  = !busy_reg;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign is_end   = busy_reg && (ctl.op == OP_END);
    assign do_emit  = busy_reg && word.emit;
    // A new word pushes the held one out; the end step flushes it as last, or a zero word if none is held
    assign push_out = (do_emit && pend_valid_reg) || is_end;
    assign step_go  = busy_reg && (!push_out || out_free);

    // Evaluate the jump condition of the current step
    always_comb begin
        unique case (ctl.cond)
            C_MORE_BITS:  jump = (cnt_reg != CNT_W'(1));
            C_GROUP_ZERO: jump = word.group_zero;
            C_NEVER:      jump = 1'b0;
            default:      jump = 1'b0;
        endcase
    end

    // Advance the sequencer, hold one word back to know which is last
    always_comb begin
        busy_next       = busy_reg;
        pc_next         = pc_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_code_next  = pend_code_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_code_next     = m_code_reg;
        m_last_next     = m_last_reg;
        if (accept) begin
            busy_next = 1'b1;
            pc_next   = PC_SHIFT;
            cnt_next  = CNT_W'(VALUE_W);
        end
        if (step_go) begin
            pc_next = jump ? ctl.target : pc_reg + PC_W'(1);
            if (ctl.op == OP_SHIFT) begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
            if (push_out) begin
                m_valid_next = 1'b1;
                m_code_next  = pend_valid_reg ? pend_code_reg : W_ZERO;
                m_last_next  = is_end;
            end
            if (do_emit) begin
                pend_valid_next = 1'b1;
                pend_code_next  = word.code;
            end
            if (is_end) begin
                pend_valid_next = 1'b0;
                busy_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            pc_reg         <= PC_SHIFT;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            pc_reg         <= pc_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        pend_code_reg <= pend_code_next;
        m_code_reg    <= m_code_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_word_code = m_code_reg;
    assign m_last_word = m_last_reg;

    // A held-back word exists only while a value is in progress
    a_pend_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> busy_reg)
        else $error("held word outside a busy run");

    // The program counter never runs past the end step
    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (pc_reg <= PC_END))
        else $error("program counter out of range");

    // Conversion never shifts with an empty bit count
    a_cnt_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && (ctl.op == OP_SHIFT)) |-> (cnt_reg != '0))
        else $error("shift with no bits left");

    // A finished run leaves its last word on the output
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (is_end && step_go) |=> (m_valid_reg && m_last_reg && !pend_valid_reg))
        else $error("end step did not flush the last word");

endmodule

[tb/sv/integer_to_word_tokens_top_tb.sv]
`timescale 1ns / 1ps
// Testbench for integer_to_word_tokens_top: random and directed values in, word codes out.
// Holds a scoreboard class that spells each accepted value; depends on itw_pkg and the top.
module integer_to_word_tokens_top_tb;
    import itw_pkg::*;

    localparam int HOLD_CYCLES   = 400;
    localparam int BURST_VALUES  = 30;
    localparam int RANDOM_VALUES = 405;
    localparam int QUIET_EVERY   = 40;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int TAIL_CYCLES   = 60;
    localparam int PRINT_CAP     = 50;

    typedef struct {
        logic [CODE_W-1:0] code;
        logic              last_word;
    } spoken_word_t;

    // Spell accepted values into expected words and compare them with the output
    class word_scoreboard;
        spoken_word_t pending_words[$];
        spoken_word_t run_words[$];
        int unsigned  values_noted  = 0;
        int unsigned  words_checked = 0;
        int unsigned  mismatches    = 0;

        task report(input string msg);
            mismatches++;
            if (mismatches <= PRINT_CAP) begin
                $display("[%0t] MISMATCH: %s", $time, msg);
            end
        endtask

        function void add_word(input int unsigned code);
            spoken_word_t w;
            w.code      = code[CODE_W-1:0];
            w.last_word = 1'b0;
            run_words.push_back(w);
        endfunction

        // Spell one nonzero base-1000 group without its scale word
        function void add_group(input int unsigned grp);
            int unsigned tail;
            tail = grp % 100;
            if (grp >= 100) begin
                add_word(grp / 100);
                add_word(W_HUNDRED);
            end
            if (tail >= 10 && tail < 20) begin
                add_word(tail);
            end else begin
                if (tail >= 20) add_word(W_TENS_BASE + tail / 10);
                if (tail % 10 != 0) add_word(tail % 10);
            end
        endfunction

        function void note_value(input logic [VALUE_W-1:0] value);
            int unsigned grp [GROUPS];
            int unsigned rest;
            rest = value;
            values_noted++;
            run_words.delete();
            if (rest == 0) begin
                add_word(W_ZERO);
            end else begin
                for (int k = 0; k < GROUPS; k++) begin
                    grp[k] = rest % 1000;
                    rest   = rest / 1000;
                end
                for (int k = GROUPS - 1; k >= 0; k--) begin
                    if (grp[k] == 0) continue;
                    add_group(grp[k]);
                    if (k > 0) add_word(W_SCALE_BASE + k);
                end
            end
            // flag the final word of this run
            run_words[run_words.size() - 1].last_word = 1'b1;
            foreach (run_words[i]) pending_words.push_back(run_words[i]);
        endfunction

        task check_word(input logic [CODE_W-1:0] code, input logic last_word);
            spoken_word_t exp_word;
            words_checked++;
            if (pending_words.size() == 0) begin
                report($sformatf("word code %0d last %0d with no value pending", code, last_word));
            end else begin
                exp_word = pending_words.pop_front();
                if (code !== exp_word.code) begin
                    report($sformatf("word_code %0d, expected %0d", code, exp_word.code));
                end
                if (last_word !== exp_word.last_word) begin
                    report($sformatf("last_word %0d, expected %0d (code %0d)",
                                     last_word, exp_word.last_word, exp_word.code));
                end
            end
        endtask
    endclass

    logic               aclk;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic [VALUE_W-1:0] s_value     = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic [CODE_W-1:0]  m_word_code;
    logic               m_last_word;

    word_scoreboard sb;
    bit             quiet        = 1'b0;
    bit             hold_request = 1'b0;
    int unsigned    hold_count   = 0;
    int unsigned    directed_cnt = 0;
    int unsigned    random_cnt   = 0;

    integer_to_word_tokens_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_word_code (m_word_code),
        .m_last_word (m_last_word)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Stop a hung run
    initial begin
        #8_000_000;
        $display("TIMEOUT at %0t", $time);
        $display("integer_to_word_tokens_top_tb failed");
        $finish;
    end

    // Pick one base-1000 group, leaning on teens, round tens and round hundreds
    function automatic int unsigned pick_group();
        case ($urandom_range(0, 5))
            0: pick_group = 0;
            1: pick_group = 100 * $urandom_range(0, 9) + $urandom_range(10, 19);
            2: pick_group = 10 * $urandom_range(0, 99);
            3: pick_group = 100 * $urandom_range(1, 9);
            default: pick_group = $urandom_range(0, 999);
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        longint unsigned v;
        bit [31:0]       raw;
        raw = $urandom;
        case ($urandom_range(0, 5))
            0: v = raw[VALUE_W-1:0];
            1: v = $urandom_range(0, 999);
            2: v = $urandom_range(0, 99999);
            3: v = 64'h7FFF_FFFF >> $urandom_range(0, 30);
            default: begin
                v = longint'($urandom_range(0, 2)) * 1_000_000_000
                  + longint'(pick_group()) * 1_000_000
                  + longint'(pick_group()) * 1_000
                  + longint'(pick_group());
                // keep the billions group inside 31 bits
                if (v > 64'h7FFF_FFFF) v = v - 1_000_000_000;
            end
        endcase
        random_value = v[VALUE_W-1:0];
    endfunction

    function automatic int draw_gap();
        draw_gap = quiet ? 0 : $urandom_range(0, 14);
    endfunction

    // Offer one value after a gap and hold it until accepted
    task automatic send_value(input logic [VALUE_W-1:0] value, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        sb.note_value(value);
    endtask

    // Drop valid and wait until every pending word has come back, or the drain limit is reached
    task automatic wait_drained();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
    endtask

    // Result side: stall per word, or hold off for a long stretch on request
    initial begin
        int stall;
        while (sb == null || !aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold_count++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                stall = draw_gap();
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_word(m_word_code, m_last_word);
        end
    end

    // Input side: directed values, a back-pressure burst, then random values
    initial begin
        logic [VALUE_W-1:0] directed_values [$];
        sb = new();
        directed_values = '{0, 1, 7, 9, 10, 13, 19, 20, 21, 45, 99, 100, 101, 110, 115,
                            999, 1000, 1001, 1000000, 1000000000, 2000000000,
                            2147483647, 1777777777, 1013017019, 1073741824};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_values[i]) begin
            send_value(directed_values[i], draw_gap());
            directed_cnt++;
        end

        // stall the output for a long stretch while values keep coming
        hold_request = 1'b1;
        for (int i = 0; i < BURST_VALUES; i++) begin
            send_value(random_value(), 0);
            random_cnt++;
        end
        wait_drained();

        for (int i = 0; i < RANDOM_VALUES; i++) begin
            if (i % QUIET_EVERY == 0) quiet = ($urandom_range(0, 3) == 0);
            if (i == RANDOM_VALUES / 2) wait_drained();
            send_value(random_value(), draw_gap());
            random_cnt++;
        end
        quiet = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.pending_words.size() != 0) begin
            sb.report($sformatf("%0d words never arrived", sb.pending_words.size()));
        end

        $display("Covered %0d values (%0d directed, %0d random) and %0d words,",
                 sb.values_noted, directed_cnt, random_cnt, sb.words_checked);
        $display("with %0d long output hold-offs; %0d mismatches.",
                 hold_count, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("integer_to_word_tokens_top_tb passed");
        end else begin
            $display("integer_to_word_tokens_top_tb failed");
        end
        $finish;
    end

endmodule

[sim.f]
src/itw_pkg.sv
src/itw_bcd.sv
src/itw_rom.sv
src/itw_word.sv
src/integer_to_word_tokens_top.sv
tb/sv/integer_to_word_tokens_top_tb.sv
